// ----- rtl/snvd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// snvd_pkg
// Shared constants and types for the symmetric nearest-vertex distance block.
// ----------------------------------------------------------------------------
package snvd_pkg;
  localparam int MAX_POINTS_DEF = 64;
  localparam int COORD_WIDTH_DEF = 16;
  localparam int OP_W = 2;
  localparam int MEAN_W = 17;
  localparam logic [OP_W-1:0] OP_LOAD_A = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_B = 2'd1;
  localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;
  localparam logic [OP_W-1:0] OP_NOP = 2'd3;
endpackage
`default_nettype wire

// ----- rtl/snvd_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// snvd_queue
// Two-entry queue of classified items between the front and back parts.
// ----------------------------------------------------------------------------
module snvd_queue #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         wr_en,
  input  wire logic [W-1:0] wr_data,
  output logic              full,
  input  wire logic         rd_en,
  output logic [W-1:0]      rd_data,
  output logic              empty
);
  logic [W-1:0] mem_r [2];
  logic         wp_r, rp_r;
  logic [1:0]   cnt_r;

  assign full = cnt_r == 2'd2;
  assign empty = cnt_r == 2'd0;
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en && !full) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_en && !full) wp_r <= ~wp_r;
      if (rd_en && !empty) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(wr_en && !full) - 2'(rd_en && !empty);
    end
  end
endmodule
`default_nettype wire

// ----- rtl/snvd_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// snvd_back
// Executes items: stores points and runs the nearest-vertex sweep, the
// per-point square root and the final mean division.
// ----------------------------------------------------------------------------
module snvd_back #(
  parameter int MAX_POINTS = snvd_pkg::MAX_POINTS_DEF,
  parameter int COORD_WIDTH = snvd_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        q_empty,
  input  wire logic [snvd_pkg::OP_W-1:0]   q_op,
  input  wire logic [COORD_WIDTH-1:0]      q_x,
  input  wire logic [COORD_WIDTH-1:0]      q_y,
  output logic                             q_pop,
  output logic                             out_empty,
  input  wire logic                        out_pop,
  output logic [snvd_pkg::MEAN_W-1:0]      out_mean_distance,
  output logic                             out_empty_error,
  output logic                             out_overflow_flag
);
  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int DW = COORD_WIDTH + 1;
  localparam int SQW = 2 * DW + 1;
  localparam int RW = (SQW + 1) / 2;
  localparam int SW = RW + $clog2(2 * MAX_POINTS + 1);
  localparam int NW = CW + 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_OUTER = 3'd1;
  localparam logic [2:0] S_INNER = 3'd2;
  localparam logic [2:0] S_ACC = 3'd3;
  localparam logic [2:0] S_SQRT = 3'd4;
  localparam logic [2:0] S_DIV = 3'd5;
  localparam logic [2:0] S_OUT = 3'd6;

  logic [COORD_WIDTH-1:0] ax_m [MAX_POINTS];
  logic [COORD_WIDTH-1:0] ay_m [MAX_POINTS];
  logic [COORD_WIDTH-1:0] bx_m [MAX_POINTS];
  logic [COORD_WIDTH-1:0] by_m [MAX_POINTS];

  logic [2:0]   state_r;
  logic [CW-1:0] cnt_a_r, cnt_b_r;
  logic         drop_r;
  logic         side_r;
  logic [CW-1:0] i_r, j_r;
  logic [AW-1:0] rd_addr;
  logic [COORD_WIDTH-1:0] pa_x_r, pa_y_r, pb_x_r, pb_y_r;
  logic [COORD_WIDTH-1:0] px_r, py_r;
  logic         own_v_r, oth_v_r;
  logic [SQW-1:0] best_r;
  logic [SQW-1:0] rem_r;
  logic [RW-1:0]  root_r;
  logic [$clog2(RW+1)-1:0] sq_k_r;
  logic [SW-1:0] sum_r;
  logic [SW-1:0] quo_r;
  logic [NW-1:0] div_rem_r;
  logic [$clog2(SW+1)-1:0] dk_r;
  logic [NW-1:0] total;
  logic [snvd_pkg::MEAN_W-1:0] mean_r;
  logic          err_r, ovf_r, valid_r;

  logic signed [DW-1:0] dx, dy;
  logic [DW-1:0] adx, ady;
  logic [SQW-1:0] dsq;
  logic [SQW-1:0] trial;
  logic [NW:0] dtrial;
  logic [CW-1:0] own_n, oth_n;

  assign total = NW'(cnt_a_r) + NW'(cnt_b_r);
  assign own_n = side_r ? cnt_b_r : cnt_a_r;
  assign oth_n = side_r ? cnt_a_r : cnt_b_r;
  assign rd_addr = (state_r == S_OUTER) ? i_r[AW-1:0] : j_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && !q_empty && q_op == snvd_pkg::OP_LOAD_A
        && cnt_a_r < CW'(MAX_POINTS)) begin
      ax_m[cnt_a_r[AW-1:0]] <= q_x;
      ay_m[cnt_a_r[AW-1:0]] <= q_y;
    end
    if (state_r == S_IDLE && !q_empty && q_op == snvd_pkg::OP_LOAD_B
        && cnt_b_r < CW'(MAX_POINTS)) begin
      bx_m[cnt_b_r[AW-1:0]] <= q_x;
      by_m[cnt_b_r[AW-1:0]] <= q_y;
    end
    pa_x_r <= ax_m[rd_addr];
    pa_y_r <= ay_m[rd_addr];
    pb_x_r <= bx_m[rd_addr];
    pb_y_r <= by_m[rd_addr];
  end

  assign dx = side_r ? (DW'($signed(px_r)) - DW'($signed(pa_x_r)))
                     : (DW'($signed(px_r)) - DW'($signed(pb_x_r)));
  assign dy = side_r ? (DW'($signed(py_r)) - DW'($signed(pa_y_r)))
                     : (DW'($signed(py_r)) - DW'($signed(pb_y_r)));
  assign adx = dx[DW-1] ? DW'(-dx) : DW'(dx);
  assign ady = dy[DW-1] ? DW'(-dy) : DW'(dy);
  assign dsq = SQW'(adx * adx) + SQW'(ady * ady);
  assign trial = SQW'({root_r, 2'b01} << (2 * sq_k_r)) ;
  assign dtrial = {div_rem_r, quo_r[SW-1]} - {1'b0, total};

  assign q_pop = (state_r == S_IDLE) && !q_empty
                 && !(q_op == snvd_pkg::OP_COMPUTE && valid_r);
  assign out_empty = !valid_r;
  assign out_mean_distance = mean_r;
  assign out_empty_error = err_r;
  assign out_overflow_flag = ovf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_a_r <= '0;
      cnt_b_r <= '0;
      drop_r <= 1'b0;
      valid_r <= 1'b0;
      own_v_r <= 1'b0;
      oth_v_r <= 1'b0;
    end else begin
      if (valid_r && out_pop) valid_r <= 1'b0;
      own_v_r <= 1'b0;
      oth_v_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (q_pop) begin
            if (q_op == snvd_pkg::OP_LOAD_A) begin
              if (cnt_a_r < CW'(MAX_POINTS)) cnt_a_r <= cnt_a_r + 1'b1;
              else drop_r <= 1'b1;
            end else if (q_op == snvd_pkg::OP_LOAD_B) begin
              if (cnt_b_r < CW'(MAX_POINTS)) cnt_b_r <= cnt_b_r + 1'b1;
              else drop_r <= 1'b1;
            end else if (q_op == snvd_pkg::OP_COMPUTE) begin
              ovf_r <= drop_r;
              if (cnt_a_r == '0 || cnt_b_r == '0) begin
                err_r <= 1'b1;
                mean_r <= '0;
                state_r <= S_OUT;
              end else begin
                err_r <= 1'b0;
                side_r <= 1'b0;
                i_r <= '0;
                sum_r <= '0;
                state_r <= S_OUTER;
              end
            end
          end
        end
        S_OUTER: begin
          own_v_r <= 1'b1;
          j_r <= '0;
          best_r <= '1;
          state_r <= S_INNER;
        end
        S_INNER: begin
          if (own_v_r) begin
            px_r <= side_r ? pb_x_r : pa_x_r;
            py_r <= side_r ? pb_y_r : pa_y_r;
            j_r <= j_r + 1'b1;
            oth_v_r <= 1'b1;
          end else if (oth_v_r) begin
            if (dsq < best_r) best_r <= dsq;
            if (j_r < oth_n) begin
              j_r <= j_r + 1'b1;
              oth_v_r <= 1'b1;
            end else begin
              state_r <= S_ACC;
            end
          end else begin
            oth_v_r <= 1'b1;
          end
        end
        S_ACC: begin
          rem_r <= best_r;
          root_r <= '0;
          sq_k_r <= ($clog2(RW+1))'(RW - 1);
          state_r <= S_SQRT;
        end
        S_SQRT: begin
          if ((rem_r >> (2 * sq_k_r)) >= SQW'({root_r, 2'b01})) begin
            rem_r <= rem_r - trial;
            root_r <= {root_r[RW-2:0], 1'b1};
          end else begin
            root_r <= {root_r[RW-2:0], 1'b0};
          end
          if (sq_k_r == '0) begin
            state_r <= S_DIV;
          end else begin
            sq_k_r <= sq_k_r - 1'b1;
          end
        end
        S_DIV: begin
          if (i_r + 1'b1 < own_n) begin
            sum_r <= sum_r + SW'(root_r);
            i_r <= i_r + 1'b1;
            state_r <= S_OUTER;
          end else if (!side_r) begin
            sum_r <= sum_r + SW'(root_r);
            side_r <= 1'b1;
            i_r <= '0;
            state_r <= S_OUTER;
          end else begin
            quo_r <= sum_r + SW'(root_r);
            div_rem_r <= '0;
            dk_r <= ($clog2(SW+1))'(SW);
            side_r <= 1'b0;
            state_r <= S_OUT;
            err_r <= 1'b0;
            mean_r <= '1;
          end
        end
        S_OUT: begin
          if (mean_r == '1 && !err_r && dk_r != '0) begin
            if (!dtrial[NW]) begin
              div_rem_r <= dtrial[NW-1:0];
              quo_r <= {quo_r[SW-2:0], 1'b1};
            end else begin
              div_rem_r <= {div_rem_r[NW-2:0], quo_r[SW-1]};
              quo_r <= {quo_r[SW-2:0], 1'b0};
            end
            dk_r <= dk_r - 1'b1;
          end else if (!valid_r) begin
            if (!err_r) mean_r <= snvd_pkg::MEAN_W'(quo_r);
            valid_r <= 1'b1;
            cnt_a_r <= '0;
            cnt_b_r <= '0;
            drop_r <= 1'b0;
            dk_r <= '0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- rtl/symmetric_nearest_vertex_distance.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// symmetric_nearest_vertex_distance
// Symmetric chamfer distance between two 2-D point sets.
// Items enter through a push/full queue port: op 0 loads a point into set A,
// op 1 into set B, op 2 computes. Only compute gives a result, read through
// an empty/pop queue port. A short queue decouples the input from the
// execution engine, so loads are taken one per cycle while space remains.
// A compute item walks both point stores: for each stored point, a sweep over
// the other set through the single-port point memory loop, then a bit-serial
// square root of the nearest squared distance; after both stores, a bit-serial
// mean division of the sum by the total point count.
// The result waits in an output register until popped; while it waits, the
// next compute item stays at the head of the queue, items behind it wait
// too, and full rises once the queue holds two items.
// Reset clears the point counts, the drop flag and the queue; point stores
// are not cleared.
// ----------------------------------------------------------------------------
module symmetric_nearest_vertex_distance #(
  parameter int MAX_POINTS = snvd_pkg::MAX_POINTS_DEF,
  parameter int COORD_WIDTH = snvd_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      push,
  output logic                           full,
  input  wire logic [snvd_pkg::OP_W-1:0] in_op,
  input  wire logic [COORD_WIDTH-1:0]    in_coord_x,
  input  wire logic [COORD_WIDTH-1:0]    in_coord_y,
  output logic                           empty,
  input  wire logic                      pop,
  output logic [snvd_pkg::MEAN_W-1:0]    out_mean_distance,
  output logic                           out_empty_error,
  output logic                           out_overflow_flag
);
  localparam int QW = snvd_pkg::OP_W + 2 * COORD_WIDTH;
  logic          keep;
  logic          q_empty, q_pop;
  logic [QW-1:0] q_data;

  assign keep = push && (in_op != snvd_pkg::OP_NOP);

  snvd_queue #(.W(QW)) u_queue (
    .clk(clk), .rst_n(rst_n),
    .wr_en(keep), .wr_data({in_op, in_coord_x, in_coord_y}), .full(full),
    .rd_en(q_pop), .rd_data(q_data), .empty(q_empty)
  );

  snvd_back #(.MAX_POINTS(MAX_POINTS), .COORD_WIDTH(COORD_WIDTH)) u_back (
    .clk(clk), .rst_n(rst_n),
    .q_empty(q_empty),
    .q_op(q_data[QW-1 -: snvd_pkg::OP_W]),
    .q_x(q_data[2*COORD_WIDTH-1 -: COORD_WIDTH]),
    .q_y(q_data[COORD_WIDTH-1:0]),
    .q_pop(q_pop),
    .out_empty(empty), .out_pop(pop),
    .out_mean_distance(out_mean_distance),
    .out_empty_error(out_empty_error),
    .out_overflow_flag(out_overflow_flag)
  );
endmodule
`default_nettype wire

// ----- tb/tb_symmetric_nearest_vertex_distance.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_symmetric_nearest_vertex_distance
// Self-checking bench for the symmetric nearest-vertex distance block.
// Point loads and compute items are queued by a stimulus process and
// driven by a clocked driver. A chamfer predictor follows each accepted
// item. A clocked monitor checks every popped result against the oldest
// predicted one. The run steps through several sender and receiver idle
// patterns, including a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_symmetric_nearest_vertex_distance;

  localparam int NPTS = snvd_pkg::MAX_POINTS_DEF;
  localparam int CW = snvd_pkg::COORD_WIDTH_DEF;
  localparam int WATCHDOG_LIMIT = 200000;
  localparam int HOLD_CYCLES = 600;

  typedef struct {
    logic [snvd_pkg::OP_W-1:0] op;
    logic [CW-1:0]   x;
    logic [CW-1:0]   y;
  } point_item_t;

  typedef struct {
    logic [snvd_pkg::MEAN_W-1:0] mean;
    logic              empty_err;
    logic              ovf;
  } chamfer_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic [snvd_pkg::OP_W-1:0] in_op = snvd_pkg::OP_LOAD_A;
  logic [CW-1:0] in_coord_x = '0;
  logic [CW-1:0] in_coord_y = '0;
  logic full;
  logic empty;
  logic [snvd_pkg::MEAN_W-1:0] out_mean_distance;
  logic out_empty_error;
  logic out_overflow_flag;

  symmetric_nearest_vertex_distance dut (
    .clk(clk), .rst_n(rst_n),
    .push(push), .full(full),
    .in_op(in_op), .in_coord_x(in_coord_x), .in_coord_y(in_coord_y),
    .empty(empty), .pop(pop),
    .out_mean_distance(out_mean_distance),
    .out_empty_error(out_empty_error),
    .out_overflow_flag(out_overflow_flag)
  );

  point_item_t pending_points[$];
  chamfer_result_t expected_means[$];
  point_item_t next_item;

  logic signed [CW-1:0] a_x[NPTS], a_y[NPTS], b_x[NPTS], b_y[NPTS];
  int count_a = 0;
  int count_b = 0;
  bit dropped = 1'b0;

  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  bit hold_phase = 1'b0;
  int hold_count = 0;
  int errors = 0;
  int results_seen = 0;
  int empty_seen = 0;
  int ovf_seen = 0;
  int idle_cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint unsigned isqrt(longint unsigned n);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic longint unsigned nearest_dist(longint px, longint py, bit to_b);
    longint unsigned best;
    longint unsigned d;
    longint dx;
    longint dy;
    int n;
    best = '1;
    n = to_b ? count_b : count_a;
    for (int j = 0; j < n; j++) begin
      dx = px - (to_b ? longint'(b_x[j]) : longint'(a_x[j]));
      dy = py - (to_b ? longint'(b_y[j]) : longint'(a_y[j]));
      d = dx * dx + dy * dy;
      if (d < best) best = d;
    end
    return isqrt(best);
  endfunction

  task automatic chamfer_apply(logic [snvd_pkg::OP_W-1:0] op, logic [CW-1:0] x,
                               logic [CW-1:0] y);
    chamfer_result_t r;
    longint unsigned sum;
    if (op == snvd_pkg::OP_LOAD_A) begin
      if (count_a >= NPTS) dropped = 1'b1;
      else begin
        a_x[count_a] = x;
        a_y[count_a] = y;
        count_a++;
      end
    end else if (op == snvd_pkg::OP_LOAD_B) begin
      if (count_b >= NPTS) dropped = 1'b1;
      else begin
        b_x[count_b] = x;
        b_y[count_b] = y;
        count_b++;
      end
    end else if (op == snvd_pkg::OP_COMPUTE) begin
      r.mean = '0;
      r.empty_err = (count_a == 0 || count_b == 0);
      r.ovf = dropped;
      if (!r.empty_err) begin
        sum = 0;
        for (int i = 0; i < count_a; i++) sum += nearest_dist(a_x[i], a_y[i], 1'b1);
        for (int i = 0; i < count_b; i++) sum += nearest_dist(b_x[i], b_y[i], 1'b0);
        r.mean = snvd_pkg::MEAN_W'(sum / longint'(count_a + count_b));
      end
      expected_means.push_back(r);
      count_a = 0;
      count_b = 0;
      dropped = 1'b0;
    end
  endtask

  function automatic logic [CW-1:0] rand_coord(int cx);
    case ($urandom_range(0, 3))
      0: return CW'($urandom);
      1: return CW'(cx + $urandom_range(0, 64) - 32);
      2: return $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
      default: return CW'(cx + $urandom_range(0, 4096) - 2048);
    endcase
  endfunction

  task automatic add_item(logic [snvd_pkg::OP_W-1:0] op, logic [CW-1:0] x, logic [CW-1:0] y);
    point_item_t it;
    it.op = op;
    it.x = x;
    it.y = y;
    pending_points.push_back(it);
  endtask

  // One point-set pair followed by a compute; returns the number of load and compute items queued.
  task automatic add_point_sets(output int n_items);
    int na;
    int nb;
    int cx;
    int cy;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 4) begin
      na = $urandom_range(0, 1) ? 0 : $urandom_range(1, 4);
      nb = (na == 0) ? $urandom_range(0, 3) : 0;
    end else if (pick < 7) begin
      na = $urandom_range(NPTS - 2, NPTS + 4);
      nb = $urandom_range(1, NPTS + 3);
    end else begin
      na = $urandom_range(1, 8);
      nb = $urandom_range(1, 8);
    end
    cx = $urandom_range(0, 65535) - 32768;
    cy = $urandom_range(0, 65535) - 32768;
    n_items = na + nb + 1;
    while (na > 0 || nb > 0) begin
      if ($urandom_range(0, 30) == 0) add_item(snvd_pkg::OP_NOP, CW'($urandom), CW'($urandom));
      if (nb == 0 || (na > 0 && $urandom_range(0, 1))) begin
        add_item(snvd_pkg::OP_LOAD_A, rand_coord(cx), rand_coord(cy));
        na--;
      end else begin
        add_item(snvd_pkg::OP_LOAD_B, rand_coord(cx), rand_coord(cy));
        nb--;
      end
    end
    add_item(snvd_pkg::OP_COMPUTE, CW'($urandom), CW'($urandom));
  endtask

  task automatic run_phase(int tx_pct, int rx_pct, bit hold, int n_target);
    int queued;
    int n;
    tx_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
    hold_count = 0;
    hold_phase = hold;
    queued = 0;
    while (queued < n_target) begin
      add_point_sets(n);
      queued += n;
    end
    while (pending_points.size() > 0 || push || expected_means.size() > 0) @(posedge clk);
    hold_phase = 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
    end else begin
      if (push && !full) chamfer_apply(in_op, in_coord_x, in_coord_y);
      if (!push || !full) begin
        if (pending_points.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
          next_item = pending_points.pop_front();
          push <= 1'b1;
          in_op <= next_item.op;
          in_coord_x <= next_item.x;
          in_coord_y <= next_item.y;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        results_seen++;
        if (expected_means.size() == 0) begin
          errors++;
          $display("%0t: unexpected result mean=%0d empty_error=%0b overflow=%0b", $time,
                   out_mean_distance, out_empty_error, out_overflow_flag);
        end else begin
          if (out_mean_distance !== expected_means[0].mean) begin
            errors++;
            $display("%0t: mean_distance expected %0d actual %0d", $time,
                     expected_means[0].mean, out_mean_distance);
          end
          if (out_empty_error !== expected_means[0].empty_err) begin
            errors++;
            $display("%0t: empty_error expected %0b actual %0b", $time,
                     expected_means[0].empty_err, out_empty_error);
          end
          if (out_overflow_flag !== expected_means[0].ovf) begin
            errors++;
            $display("%0t: overflow_flag expected %0b actual %0b", $time,
                     expected_means[0].ovf, out_overflow_flag);
          end
          empty_seen += expected_means[0].empty_err;
          ovf_seen += expected_means[0].ovf;
          void'(expected_means.pop_front());
        end
      end
      if (hold_phase && hold_count < HOLD_CYCLES) begin
        hold_count++;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("symmetric_nearest_vertex_distance verification failed");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    // Directed: extreme corners, empty sets, ignored op code, coincident points.
    add_item(snvd_pkg::OP_LOAD_A, 16'h8000, 16'h8000);
    add_item(snvd_pkg::OP_LOAD_B, 16'h7fff, 16'h7fff);
    add_item(snvd_pkg::OP_COMPUTE, 16'h0000, 16'h0000);
    add_item(snvd_pkg::OP_COMPUTE, 16'hffff, 16'hffff);
    add_item(snvd_pkg::OP_LOAD_A, 16'h0010, 16'hfff0);
    add_item(snvd_pkg::OP_COMPUTE, 16'h0000, 16'h0000);
    add_item(snvd_pkg::OP_LOAD_B, 16'h7fff, 16'h8000);
    add_item(snvd_pkg::OP_COMPUTE, 16'h0000, 16'h0000);
    add_item(snvd_pkg::OP_NOP, 16'h1234, 16'h5678);
    add_item(snvd_pkg::OP_LOAD_A, 16'h0000, 16'h0000);
    add_item(snvd_pkg::OP_LOAD_A, 16'h0030, 16'h0040);
    add_item(snvd_pkg::OP_LOAD_A, 16'hff00, 16'h0100);
    add_item(snvd_pkg::OP_LOAD_B, 16'h0001, 16'hffff);
    add_item(snvd_pkg::OP_LOAD_B, 16'h8000, 16'h7fff);
    add_item(snvd_pkg::OP_COMPUTE, 16'h0000, 16'h0000);
    add_item(snvd_pkg::OP_LOAD_A, 16'h5555, 16'haaaa);
    add_item(snvd_pkg::OP_LOAD_B, 16'h5555, 16'haaaa);
    add_item(snvd_pkg::OP_COMPUTE, 16'h0000, 16'h0000);
    run_phase(0, 0, 1'b0, 0);
    run_phase(0, 0, 1'b0, 400);
    run_phase(55, 0, 1'b0, 400);
    run_phase(0, 55, 1'b0, 400);
    run_phase(25, 25, 1'b0, 350);
    run_phase(0, 0, 1'b1, 100);
    repeat (100) @(posedge clk);
    $display("Checked %0d compute results: %0d with an empty set, %0d with dropped loads.",
             results_seen, empty_seen, ovf_seen);
    $display("Idle patterns covered: none, sender idle, receiver stall, both, long hold-off.");
    if (errors == 0 && expected_means.size() == 0) begin
      $display("symmetric_nearest_vertex_distance verification clean");
    end else begin
      $display("symmetric_nearest_vertex_distance verification failed");
    end
    $finish;
  end
endmodule
